@@ sv/mm3_pkg.sv @@
// ----------------------------------------------------------------------------
// mm3_pkg
// Constants, sequencer states and shared-unit opcodes for the word hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package mm3_pkg;

  localparam int unsigned WordWidth = 32;

  localparam logic [WordWidth-1:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [WordWidth-1:0] MIX_C2  = 32'h1b873593;
  localparam logic [WordWidth-1:0] MIX_ADD = 32'he6546b64;
  localparam logic [WordWidth-1:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [WordWidth-1:0] FIN_C2  = 32'hc2b2ae35;

  localparam logic [WordWidth-1:0] SEED_RESET = '0;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KMUL1,
    S_KMUL2,
    S_MIX,
    S_FMUL1,
    S_FMUL2,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_KMUL1,
    OP_KMUL2,
    OP_FMUL1,
    OP_FMUL2
  } op_t;

  function automatic word_t rotl15(input word_t v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic word_t rotl12(input word_t v);
    return {v[19:0], v[31:20]};
  endfunction

endpackage

`default_nettype wire

@@ sv/mm3_if.sv @@
// ----------------------------------------------------------------------------
// mm3 channel interfaces
// Valid/ready channels for input words, digests and seed writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm3_word_if;
  logic              valid;
  logic              ready;
  mm3_pkg::word_t    word;
  logic              start_req;

  modport source (output valid, output word, output start_req, input ready);
  modport sink   (input valid, input word, input start_req, output ready);
endinterface

interface mm3_digest_if;
  logic              valid;
  logic              ready;
  mm3_pkg::word_t    digest;

  modport source (output valid, output digest, input ready);
  modport sink   (input valid, input digest, output ready);
endinterface

interface mm3_cfg_if;
  logic              valid;
  logic              ready;
  mm3_pkg::word_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/mm3_mul_unit.sv @@
// ----------------------------------------------------------------------------
// mm3_mul_unit
// Shared 32x32 multiplier (low half kept) with operand selection per opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_mul_unit (
  input  wire logic           clk,
  input  wire mm3_pkg::op_t   op,
  input  wire mm3_pkg::word_t word_q,
  input  wire mm3_pkg::word_t hash,
  output mm3_pkg::word_t      prod
);
  import mm3_pkg::*;

  word_t opa;
  word_t opb;
  word_t full;

  always_comb begin
    unique case (op)
      OP_KMUL1: begin
        opa = word_q;
        opb = MIX_C1;
      end
      OP_KMUL2: begin
        opa = rotl15(prod);
        opb = MIX_C2;
      end
      OP_FMUL1: begin
        opa = hash ^ (hash >> 16);
        opb = FIN_C1;
      end
      OP_FMUL2: begin
        opa = prod ^ (prod >> 13);
        opb = FIN_C2;
      end
      default: begin
        opa = prod;
        opb = '0;
      end
    endcase
  end

  assign full = opa * opb;

  // hold the product on idle steps
  always_ff @(posedge clk) begin
    if (op != OP_HOLD) begin
      prod <= full;
    end
  end

endmodule

`default_nettype wire

@@ sv/murmur3_word_hash_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// murmur3_word_hash_accumulator_top
// Streaming MurmurHash3-style word mixer (mix step rotates by 12) with fmix32 digest per word.
// ----------------------------------------------------------------------------
// Usage:
//   words   : one 32-bit word per handshake; start_req reloads the running
//             hash from the seed before the word is mixed in.
//   digests : one fmix32 digest per word, held in an output register until
//             taken.
//   cfg     : seed write channel, always ready; write only while idle.
// Sequence: words are taken only in idle; each then steps through KMUL1,
//   KMUL2, MIX, FMUL1, FMUL2 and DONE, and the single shared multiplier does
//   four dependent products per word under a seven-state sequencer.
// Reset (synchronous): seed and running hash clear to zero, digest channel
//   empties, the sequencer returns to idle.
// Receiver stall: the sequencer waits in its last step until the output
//   register is free and stays not ready for new words meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur3_word_hash_accumulator_top (
  input  wire logic clk,
  input  wire logic rst,
  mm3_word_if.sink     words,
  mm3_digest_if.source digests,
  mm3_cfg_if.sink      cfg
);
  import mm3_pkg::*;

  state_t state;
  state_t state_next;
  op_t    op;

  word_t  seed;
  word_t  hash;
  word_t  word_q;
  logic   start_q;
  word_t  prod;
  word_t  mix_h;
  logic   out_free;

  assign out_free = !digests.valid || digests.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg.valid) begin
      seed <= cfg.data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (words.valid) state_next = S_KMUL1;
      S_KMUL1: state_next = S_KMUL2;
      S_KMUL2: state_next = S_MIX;
      S_MIX:   state_next = S_FMUL1;
      S_FMUL1: state_next = S_FMUL2;
      S_FMUL2: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    words.ready = 1'b0;
    op          = OP_HOLD;
    unique case (state)
      S_IDLE:  words.ready = 1'b1;
      S_KMUL1: op = OP_KMUL1;
      S_KMUL2: op = OP_KMUL2;
      S_FMUL1: op = OP_FMUL1;
      S_FMUL2: op = OP_FMUL2;
      default: op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      word_q  <= words.word;
      start_q <= words.start_req;
    end
  end

  mm3_mul_unit u_mul (
    .clk    (clk),
    .op     (op),
    .word_q (word_q),
    .hash   (hash),
    .prod   (prod)
  );

  // h = rotl12(h ^ k); h*5 done as shift-add
  always_comb begin
    mix_h = rotl12((start_q ? seed : hash) ^ prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (state == S_MIX) begin
      hash <= {mix_h[29:0], 2'b00} + mix_h + MIX_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digests.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      digests.valid <= 1'b1;
    end else if (digests.ready) begin
      digests.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      digests.digest <= prod ^ (prod >> 16);
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    words.valid && words.ready |=> state == S_KMUL1)
    else $error("accepted word did not start the sequencer");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> digests.valid && state == S_IDLE)
    else $error("finished digest not delivered");

  a_rose_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(digests.valid) |-> $past(state) == S_DONE)
    else $error("digest appeared without a finished word");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !out_free |=> state == S_DONE && !words.ready)
    else $error("sequencer left the final step while output was blocked");

endmodule

`default_nettype wire
